// ----- rtl/sha1_pkg.sv -----
// ----------------------------------------------------------------------------
// sha1_pkg
// shared types, constants and the initial-value helper of the sha-1 digest block
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam int LengthBitsDefault = 64;
    localparam int CmdDepth          = 4;
    localparam int CountWidth        = 61;

    typedef enum logic [1:0] {
        ACT_DATA     = 2'd0,
        ACT_DATA_END = 2'd1,
        ACT_END      = 2'd2,
        ACT_UNUSED   = 2'd3
    } t_action;

    // one queued command from the front to the core
    typedef struct packed {
        logic       has_byte;
        logic       ends;
        logic [7:0] data;
    } t_cmd;

    typedef logic [31:0] t_word;

    localparam t_word H0 = 32'h67452301;
    localparam t_word H1 = 32'hEFCDAB89;
    localparam t_word H2 = 32'h98BADCFE;
    localparam t_word H3 = 32'h10325476;
    localparam t_word H4 = 32'hC3D2E1F0;
    localparam t_word K0 = 32'h5A827999;
    localparam t_word K1 = 32'h6ED9EBA1;
    localparam t_word K2 = 32'h8F1BBCDC;
    localparam t_word K3 = 32'hCA62C1D6;
    localparam logic [7:0] PadByte = 8'h80;

    function automatic t_word init_word(input logic [2:0] idx);
        t_word v;
        case (idx)
            3'd0: v = H0;
            3'd1: v = H1;
            3'd2: v = H2;
            3'd3: v = H3;
            default: v = H4;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/sha1_message_digest.sv -----
// ----------------------------------------------------------------------------
// sha1_message_digest
// sha-1 digest of a byte stream, five 32-bit digest words per message
// ----------------------------------------------------------------------------
// input channel: a beat is taken when push is high and full is low; it carries
//   i_action (0 byte, 1 byte ending the message, 2 end without byte, 3 ignored)
//   and i_data_byte
// a four-entry command queue sits between the input and the compression core,
//   so beats keep coming while the core runs rounds or waits on the output
// the core absorbs one byte per cycle while idle and runs one round per cycle:
//   a full 64-byte block is absorbed, then compressed in 80 rounds and the
//   chain add; no bytes are taken while the core compresses
// a message end adds one or two compressions, each with a padding state ahead
//   of it (two when fewer than 9 bytes of room remain in the last block)
// result channel: while empty is low the digest word, its index (0 most
//   significant) and last_word are on the ports; a beat leaves on pop
// five result beats per message; the core holds while the receiver stalls
//   and the input queue fills, then full goes high
// after the fifth beat the chain value returns to the sha-1 initial values
// reset (synchronous, active low) empties the queue, clears the byte count
//   and loads the initial chain value; no clearing pass is needed
// ----------------------------------------------------------------------------
module sha1_message_digest #(
    parameter int LENGTH_BITS = sha1_pkg::LengthBitsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    logic           w_cmd_valid;
    logic           w_cmd_take;
    sha1_pkg::t_cmd w_cmd;

    // front: accept and classify beats
    sha1_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_action    (i_action),
        .i_data_byte (i_data_byte),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    // back: block packing, padding, rounds and digest hand-off
    sha1_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_cmd_valid),
        .i_cmd         (w_cmd),
        .o_cmd_take    (w_cmd_take),
        .empty         (empty),
        .pop           (pop),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    // last_word marks exactly the fifth digest beat
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_last_word == (o_word_index == 3'd4)))
        else $error("last_word out of step with word_index");

    // taking the last word ends the digest burst
    a_last_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_last_word) |=> empty)
        else $error("digest burst did not end after last word");

    // index steps by one on each taken non-final beat
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last_word) |=>
            (!empty && o_word_index == $past(o_word_index) + 3'd1))
        else $error("digest word index skipped");

    // a burst always opens on word zero
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(empty) |-> (o_word_index == 3'd0))
        else $error("digest burst did not start at word zero");

endmodule

// ----- rtl/sha1_front.sv -----
// ----------------------------------------------------------------------------
// sha1_front
// accepts input beats, drops unused actions, queues commands for the core
// ----------------------------------------------------------------------------
module sha1_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          i_action,
    input  logic [7:0]          i_data_byte,
    output logic                o_cmd_valid,
    output sha1_pkg::t_cmd      o_cmd,
    input  logic                i_cmd_take
);
    localparam int IdxW = $clog2(sha1_pkg::CmdDepth);

    sha1_pkg::t_cmd r_mem [sha1_pkg::CmdDepth];
    logic [IdxW-1:0] r_wr;
    logic [IdxW-1:0] r_rd;
    logic [IdxW:0]   r_cnt;
    logic            w_acc;
    logic            w_keep;
    logic            w_take;
    sha1_pkg::t_cmd  w_new;

    assign full        = (r_cnt == (IdxW+1)'(sha1_pkg::CmdDepth));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_mem[r_rd];
    assign w_acc       = push && !full;
    assign w_keep      = w_acc && (i_action != sha1_pkg::ACT_UNUSED);
    assign w_take      = i_cmd_take && o_cmd_valid;

    always_comb begin
        w_new.has_byte = (i_action == sha1_pkg::ACT_DATA) ||
                         (i_action == sha1_pkg::ACT_DATA_END);
        w_new.ends     = (i_action == sha1_pkg::ACT_DATA_END) ||
                         (i_action == sha1_pkg::ACT_END);
        w_new.data     = i_data_byte;
    end

    always_ff @(posedge i_clk) begin
        if (w_keep) begin
            r_mem[r_wr] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_keep) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_take) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({w_keep, w_take})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- rtl/sha1_core.sv -----
// ----------------------------------------------------------------------------
// sha1_core
// packs bytes into the block, pads, runs the 80 rounds, hands out the digest
// ----------------------------------------------------------------------------
module sha1_core #(
    parameter int LENGTH_BITS = sha1_pkg::LengthBitsDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  sha1_pkg::t_cmd      i_cmd,
    output logic                o_cmd_take,
    output logic                empty,
    input  logic                pop,
    output logic [31:0]         o_digest_word,
    output logic [2:0]          o_word_index,
    output logic                o_last_word
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_PAD2  = 6'b000100,
        S_ROUND = 6'b001000,
        S_ADD   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    function automatic logic [63:0] len_mask();
        logic [63:0] m;
        for (int j = 0; j < 64; j++) begin
            m[j] = (j < LENGTH_BITS);
        end
        return m;
    endfunction

    localparam logic [63:0] LenMask = len_mask();

    t_state        r_state;
    t_state        r_after;
    sha1_pkg::t_word r_w   [16];
    sha1_pkg::t_word r_h   [5];
    sha1_pkg::t_word r_v   [5];
    logic [sha1_pkg::CountWidth-1:0] r_count;
    logic [6:0]    r_round;
    logic [2:0]    r_idx;

    logic [5:0]    w_pos;
    logic [63:0]   w_bits;
    sha1_pkg::t_word w_put;
    sha1_pkg::t_word w_pad [16];
    sha1_pkg::t_word w_sched;
    sha1_pkg::t_word w_f;
    sha1_pkg::t_word w_k;
    sha1_pkg::t_word w_tmp;

    assign w_pos      = r_count[5:0];
    assign w_bits     = {r_count, 3'b000} & LenMask;
    assign o_cmd_take = (r_state == S_IDLE);

    // byte merged into its word, big-endian within the word
    always_comb begin
        w_put = r_w[w_pos[5:2]];
        case (w_pos[1:0])
            2'd0:    w_put = {i_cmd.data, 24'h0};
            2'd1:    w_put[23:16] = i_cmd.data;
            2'd2:    w_put[15:8]  = i_cmd.data;
            default: w_put[7:0]   = i_cmd.data;
        endcase
    end

    // padded block: 0x80 at the current position, zeros after, length if it fits
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            w_pad[i] = r_w[i];
            for (int b = 0; b < 4; b++) begin
                if (i > int'(w_pos[5:2]) ||
                    (i == int'(w_pos[5:2]) && b > int'(w_pos[1:0]))) begin
                    w_pad[i][31-8*b -: 8] = 8'h00;
                end else if (i == int'(w_pos[5:2]) && b == int'(w_pos[1:0])) begin
                    w_pad[i][31-8*b -: 8] = sha1_pkg::PadByte;
                end
            end
        end
        if (w_pos < 6'd56) begin
            w_pad[14] = w_bits[63:32];
            w_pad[15] = w_bits[31:0];
        end
    end

    // one round
    always_comb begin
        w_sched = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_sched = {w_sched[30:0], w_sched[31]};
        if (r_round < 7'd20) begin
            w_f = (r_v[1] & r_v[2]) | (~r_v[1] & r_v[3]);
            w_k = sha1_pkg::K0;
        end else if (r_round < 7'd40) begin
            w_f = r_v[1] ^ r_v[2] ^ r_v[3];
            w_k = sha1_pkg::K1;
        end else if (r_round < 7'd60) begin
            w_f = (r_v[1] & r_v[2]) | (r_v[1] & r_v[3]) | (r_v[2] & r_v[3]);
            w_k = sha1_pkg::K2;
        end else begin
            w_f = r_v[1] ^ r_v[2] ^ r_v[3];
            w_k = sha1_pkg::K3;
        end
        w_tmp = {r_v[0][26:0], r_v[0][31:27]} + w_f + r_v[4] + w_k + r_w[0];
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && i_cmd.has_byte) begin
                    r_w[w_pos[5:2]] <= w_put;
                end
            end
            S_PAD: begin
                for (int i = 0; i < 16; i++) begin
                    r_w[i] <= w_pad[i];
                end
            end
            S_PAD2: begin
                for (int i = 0; i < 14; i++) begin
                    r_w[i] <= '0;
                end
                r_w[14] <= w_bits[63:32];
                r_w[15] <= w_bits[31:0];
            end
            S_ROUND: begin
                for (int i = 0; i < 15; i++) begin
                    r_w[i] <= r_w[i+1];
                end
                r_w[15] <= w_sched;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_after <= S_IDLE;
            r_count <= '0;
            r_round <= '0;
            r_idx   <= '0;
            for (int i = 0; i < 5; i++) begin
                r_h[i] <= sha1_pkg::init_word(3'(i));
                r_v[i] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.has_byte) begin
                            r_count <= r_count + 1'b1;
                        end
                        if (i_cmd.has_byte && w_pos == 6'd63) begin
                            r_state <= S_ROUND;
                            r_after <= i_cmd.ends ? S_PAD : S_IDLE;
                            r_round <= '0;
                            r_v     <= r_h;
                        end else if (i_cmd.ends) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_state <= S_ROUND;
                    r_after <= (w_pos >= 6'd56) ? S_PAD2 : S_OUT;
                    r_round <= '0;
                    r_v     <= r_h;
                end
                S_PAD2: begin
                    r_state <= S_ROUND;
                    r_after <= S_OUT;
                    r_round <= '0;
                    r_v     <= r_h;
                end
                S_ROUND: begin
                    r_v[0] <= w_tmp;
                    r_v[1] <= r_v[0];
                    r_v[2] <= {r_v[1][1:0], r_v[1][31:2]};
                    r_v[3] <= r_v[2];
                    r_v[4] <= r_v[3];
                    if (r_round == 7'd79) begin
                        r_state <= S_ADD;
                        r_round <= '0;
                    end else begin
                        r_round <= r_round + 1'b1;
                    end
                end
                S_ADD: begin
                    for (int i = 0; i < 5; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    r_state <= r_after;
                    r_idx   <= '0;
                end
                S_OUT: begin
                    if (pop) begin
                        if (r_idx == 3'd4) begin
                            r_state <= S_IDLE;
                            r_count <= '0;
                            for (int i = 0; i < 5; i++) begin
                                r_h[i] <= sha1_pkg::init_word(3'(i));
                            end
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign empty         = (r_state != S_OUT);
    assign o_digest_word = r_h[r_idx];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == 3'd4);

endmodule

// ----- tb/tb_sha1_message_digest.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sha1_message_digest
// byte-stream sha-1 digest: directed messages at the padding boundaries, the
// ignored action, a backpressure run, then random messages; a local sha-1
// model predicts the five digest beats of every message and a checker
// compares each popped beat
module tb_sha1_message_digest;

    typedef struct {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_digest_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  i_action;
    logic [7:0]  i_data_byte;
    logic        empty;
    logic        pop;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    sha1_message_digest DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_action     (i_action),
        .i_data_byte  (i_data_byte),
        .empty        (empty),
        .pop          (pop),
        .o_digest_word(o_digest_word),
        .o_word_index (o_word_index),
        .o_last_word  (o_last_word)
    );

    // predictor state
    logic [31:0] msg_block [16];
    logic [31:0] chain [5];
    logic [60:0] byte_count;

    t_digest_beat pending_digests [$];
    int mismatch_count;
    bit sink_stall_on;     // random stalls on the result side
    int sink_hold_cycles;  // long hold-off requested of the sink

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // generous limit for the whole run, stalls included
    initial begin
        #20ms;
        $display("sha1_message_digest test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // local sha-1 model
    // ------------------------------------------------------------------------
    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] a, b, c, d, e, f, k, w, t;
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
        for (int r = 0; r < 80; r++) begin
            if (r >= 16) begin
                w = msg_block[(r - 3) & 15] ^ msg_block[(r - 8) & 15]
                  ^ msg_block[(r - 14) & 15] ^ msg_block[r & 15];
                msg_block[r & 15] = rol(w, 1);
            end
            w = msg_block[r & 15];
            if (r < 20) begin
                f = (b & c) | (~b & d); k = sha1_pkg::K0;
            end else if (r < 40) begin
                f = b ^ c ^ d; k = sha1_pkg::K1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d); k = sha1_pkg::K2;
            end else begin
                f = b ^ c ^ d; k = sha1_pkg::K3;
            end
            t = rol(a, 5) + f + e + k + w;
            e = d; d = c; c = rol(b, 30); b = a; a = t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endtask

    task automatic place_byte(input int pos, input logic [7:0] val);
        if ((pos & 3) == 0) msg_block[pos >> 2] = {val, 24'h0};
        else msg_block[pos >> 2] |= 32'(val) << (24 - 8 * (pos & 3));
    endtask

    task automatic absorb_byte(input logic [7:0] val);
        int pos;
        pos = int'(byte_count[5:0]);
        place_byte(pos, val);
        byte_count = byte_count + 61'd1;
        if (pos == 63) compress_block();
    endtask

    task automatic load_init_chain();
        chain[0] = sha1_pkg::H0;
        chain[1] = sha1_pkg::H1;
        chain[2] = sha1_pkg::H2;
        chain[3] = sha1_pkg::H3;
        chain[4] = sha1_pkg::H4;
    endtask

    task automatic close_message();
        int pos;
        logic [63:0] bit_len;
        t_digest_beat db;
        pos = int'(byte_count[5:0]);
        bit_len = {byte_count, 3'b000};
        place_byte(pos, sha1_pkg::PadByte);
        for (int i = pos + 1; i < 64; i++) place_byte(i, 8'h00);
        if (pos >= 56) begin
            compress_block();
            for (int i = 0; i < 16; i++) msg_block[i] = '0;
        end
        msg_block[14] = bit_len[63:32];
        msg_block[15] = bit_len[31:0];
        compress_block();
        for (int i = 0; i < 5; i++) begin
            db.digest_word = chain[i];
            db.word_index  = 3'(i);
            db.last_word   = (i == 4);
            pending_digests.push_back(db);
        end
        load_init_chain();
        byte_count = '0;
    endtask

    task automatic predict_beat(input sha1_pkg::t_action act, input logic [7:0] val);
        case (act)
            sha1_pkg::ACT_DATA: begin
                absorb_byte(val);
            end
            sha1_pkg::ACT_DATA_END: begin
                absorb_byte(val);
                close_message();
            end
            sha1_pkg::ACT_END: begin
                close_message();
            end
            default: begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------------
    bit src_idle_on;

    // push stays high on return so beats can follow back to back
    task automatic send_beat(input sha1_pkg::t_action act, input logic [7:0] val);
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        push        <= 1'b1;
        i_action    <= act;
        i_data_byte <= val;
        // wait for the accepting edge
        do @(posedge i_clk); while (full);
        predict_beat(act, val);
        @(negedge i_clk);
    endtask

    task automatic send_message(input int len, input bit end_with_byte);
        for (int i = 0; i < len; i++) begin
            if (end_with_byte && i == len - 1)
                send_beat(sha1_pkg::ACT_DATA_END, 8'($urandom));
            else
                send_beat(sha1_pkg::ACT_DATA, 8'($urandom));
        end
        if (!end_with_byte || len == 0) send_beat(sha1_pkg::ACT_END, 8'($urandom));
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_digests.size() != 0) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // result checker and sink
    // ------------------------------------------------------------------------
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_cycles > 0) begin
                pop <= 1'b0;
                sink_hold_cycles--;
            end else if (sink_stall_on && $urandom_range(0, 5) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge i_clk);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_digest_beat exp_beat;
        if (i_rst_n && pop && !empty) begin
            if (pending_digests.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected digest beat %h idx %0d", o_digest_word,
                             o_word_index);
            end else begin
                exp_beat = pending_digests.pop_front();
                if (o_digest_word !== exp_beat.digest_word
                        || o_word_index !== exp_beat.word_index
                        || o_last_word !== exp_beat.last_word) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                 exp_beat.digest_word, exp_beat.word_index,
                                 exp_beat.last_word, o_digest_word, o_word_index,
                                 o_last_word);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        // empty message, then the known "abc" digest path
        send_beat(sha1_pkg::ACT_END, 8'hFF);
        send_beat(sha1_pkg::ACT_DATA, 8'h61);
        send_beat(sha1_pkg::ACT_DATA, 8'h62);
        send_beat(sha1_pkg::ACT_DATA_END, 8'h63);
        // ignored action between beats, with all data bits set and clear
        send_beat(sha1_pkg::ACT_UNUSED, 8'hFF);
        send_beat(sha1_pkg::ACT_DATA, 8'h00);
        send_beat(sha1_pkg::ACT_UNUSED, 8'h00);
        send_beat(sha1_pkg::ACT_DATA_END, 8'hFF);
    endtask

    task automatic test_padding_edges();
        // 55/56 bytes: length fits or spills; 63/64: block boundary
        send_message(55, 1'b1);
        send_message(56, 1'b0);
        send_message(63, 1'b1);
        send_message(64, 1'b0);
    endtask

    task automatic test_backpressure();
        // sink holds off while the sender keeps offering, filling the queue
        sink_hold_cycles = 400;
        send_message(40, 1'b1);
        send_message(3, 1'b0);
        wait_drained();
    endtask

    task automatic test_random(input int budget);
        int sent, len;
        sent = 0;
        while (sent < budget) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 130)
                                               : $urandom_range(0, 20);
            if ($urandom_range(0, 9) == 0)
                send_beat(sha1_pkg::ACT_UNUSED, 8'($urandom));
            send_message(len, $urandom_range(0, 1));
            sent += len + 1;
            if ($urandom_range(0, 7) == 0) wait_drained();
        end
    endtask

    initial begin
        mismatch_count   = 0;
        sink_stall_on    = 1'b0;
        sink_hold_cycles = 0;
        src_idle_on      = 1'b0;
        push        = 1'b0;
        i_action    = sha1_pkg::ACT_DATA;
        i_data_byte = 8'h00;
        i_rst_n     = 1'b0;
        for (int i = 0; i < 16; i++) msg_block[i] = '0;
        load_init_chain();
        byte_count = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_padding_edges();
        sink_stall_on = 1'b1;
        src_idle_on   = 1'b1;
        test_backpressure();
        test_random(45);
        // last part with no idling
        sink_stall_on = 1'b0;
        src_idle_on   = 1'b0;
        test_random(25);

        wait_drained();
        repeat (300) @(negedge i_clk);
        if (mismatch_count == 0 && pending_digests.size() == 0)
            $display("sha1_message_digest test passed");
        else
            $display("sha1_message_digest test failed");
        $finish;
    end

endmodule
